/* design/tcpt_pkg.sv */
// ----------------------------------------------------------------------------
// tcpt_pkg: shared definitions for the timed cover position tracker
// Field widths, bus command bytes, operation and publish codes, register
// indexes, reset values and the result descriptor passed to the output stage.
// ----------------------------------------------------------------------------
package tcpt_pkg;

    // Fraction width of position and tilt by default.
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int ELAPSED_W = 16;
    localparam int TIME_W    = 20;
    localparam int ADDR_W    = 8;
    localparam int CMD_W     = 8;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int SINCE_W   = 16;

    // A periodic position publish fires once the counter passes this period.
    localparam logic [SINCE_W-1:0] PUBLISH_PERIOD_MS = 16'd1000;

    // Request kinds on the input channel.
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CALL = 2'd2;

    // Bus command bytes.
    localparam logic [CMD_W-1:0] CMD_NONE = 8'h00;
    localparam logic [CMD_W-1:0] CMD_UP   = 8'h09;
    localparam logic [CMD_W-1:0] CMD_DOWN = 8'h08;
    localparam logic [CMD_W-1:0] CMD_STOP = 8'h0a;

    // Motor operation.
    typedef enum logic [1:0] {
        OP_IDLE    = 2'd0,
        OP_OPENING = 2'd1,
        OP_CLOSING = 2'd2,
        OP_SPARE   = 2'd3
    } t_op;

    // Publish event carried with a result.
    typedef enum logic [1:0] {
        PUB_NONE     = 2'd0,
        PUB_FULL     = 2'd1,
        PUB_PERIODIC = 2'd2,
        PUB_SPARE    = 2'd3
    } t_pub;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_TIME   = 2'd0,
        REG_CLOSE_TIME  = 2'd1,
        REG_TILT_TIME   = 2'd2,
        REG_DEVICE_ADDR = 2'd3
    } t_reg_idx;

    // Configuration reset values.
    localparam logic [TIME_W-1:0] OPEN_TIME_RST  = 20'd30000;
    localparam logic [TIME_W-1:0] CLOSE_TIME_RST = 20'd30000;
    localparam logic [TIME_W-1:0] TILT_TIME_RST  = 20'd1500;
    localparam logic [ADDR_W-1:0] ADDR_RST       = 8'd0;

    // Fixed-width part of one result.
    typedef struct packed {
        logic             send_valid;
        logic [CMD_W-1:0] send_command;
        t_op              operation;
        t_pub             publish;
        logic             last;
    } t_emit;

    // Drive command that matches an operation.
    function automatic logic [CMD_W-1:0] op_command(input t_op op);
        logic [CMD_W-1:0] cmd;
        case (op)
            OP_OPENING: cmd = CMD_UP;
            OP_CLOSING: cmd = CMD_DOWN;
            default:    cmd = CMD_STOP;
        endcase
        return cmd;
    endfunction

endpackage

/* design/timed_cover_position_tracker_unit.sv */
// ----------------------------------------------------------------------------
// timed_cover_position_tracker_unit: time-based cover position estimator
// Tracks position and tilt of a motorized blind from motor run time, handles
// bus commands and control calls, and issues bus commands and publish events.
//
//   Channel   Signals                                   Direction
//   input     i_in_valid / o_in_ready, request fields   consumer
//   result    o_out_valid / i_out_ready, result fields  producer
//   config    i_cfg_valid / o_cfg_ready, index, data    consumer, always ready
//
// A moving tick runs the divide and update steps, plus a periodic publish step
// when due; both bit-serial dividers make a quotient bit per cycle in parallel
// and are skipped when both movements saturate. A bus command runs the bus step,
// a control call the stop, position and tilt steps. Reset is synchronous, active
// low, no clearing. o_in_ready is high only while no request is in work; a full
// output register holds the sequencer only at steps that produce a result.
// ----------------------------------------------------------------------------
module timed_cover_position_tracker_unit #(
    parameter int FRAC_BITS = tcpt_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tcpt_pkg::KIND_W-1:0]    i_kind,
    input  logic [tcpt_pkg::ELAPSED_W-1:0] i_elapsed_ms,
    input  logic [tcpt_pkg::CMD_W-1:0]     i_bus_command,
    input  logic                           i_do_stop,
    input  logic                           i_has_position,
    input  logic [FRAC_BITS-1:0]           i_target_pos,
    input  logic                           i_has_tilt,
    input  logic [FRAC_BITS-1:0]           i_target_tilt_in,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_send_valid,
    output logic [tcpt_pkg::CMD_W-1:0]     o_send_command,
    output logic [tcpt_pkg::ADDR_W-1:0]    o_send_address,
    output logic [FRAC_BITS-1:0]           o_position_now,
    output logic [FRAC_BITS-1:0]           o_tilt_now,
    output logic [1:0]                     o_operation,
    output logic [1:0]                     o_publish,
    output logic                           o_last,
    // Configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tcpt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcpt_pkg::TIME_W-1:0]    i_cfg_data
);
    import tcpt_pkg::*;

    localparam logic [FRAC_BITS-1:0] FULL = {FRAC_BITS{1'b1}};
    localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DIV      = 8'b0000_0010,
        S_UPDATE   = 8'b0000_0100,
        S_PERIODIC = 8'b0000_1000,
        S_BUS      = 8'b0001_0000,
        S_STOP     = 8'b0010_0000,
        S_POS      = 8'b0100_0000,
        S_TILT     = 8'b1000_0000
    } t_state;

    // Saturating move of an estimate toward open or closed.
    function automatic logic [FRAC_BITS-1:0] step_value(
        input logic [FRAC_BITS-1:0] v,
        input logic [FRAC_BITS-1:0] d,
        input logic                 up
    );
        logic [FRAC_BITS:0]   sum;
        logic [FRAC_BITS-1:0] res;
        sum = {1'b0, v} + {1'b0, d};
        if (up) begin
            res = sum[FRAC_BITS] ? FULL : sum[FRAC_BITS-1:0];
        end else begin
            res = (v < d) ? '0 : (v - d);
        end
        return res;
    endfunction

    // Sequencer and tracker state.
    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [FRAC_BITS-1:0] r_pos, n_pos;
    logic [FRAC_BITS-1:0] r_tilt, n_tilt;
    logic [FRAC_BITS-1:0] r_goal_pos, n_goal_pos;
    logic [FRAC_BITS-1:0] r_goal_tilt, n_goal_tilt;
    logic                 r_bus_trig, n_bus_trig;
    logic [SINCE_W-1:0]   r_since, n_since;
    logic                 r_per, n_per;

    // Configuration registers.
    logic [TIME_W-1:0]    r_open_time;
    logic [TIME_W-1:0]    r_close_time;
    logic [TIME_W-1:0]    r_tilt_time;
    logic [ADDR_W-1:0]    r_addr;

    // Captured request fields.
    logic [CMD_W-1:0]     r_bus_cmd;
    logic                 r_do_stop;
    logic                 r_has_pos;
    logic [FRAC_BITS-1:0] r_tpos;
    logic                 r_has_tilt;
    logic [FRAC_BITS-1:0] r_ttilt;

    logic                 w_accept;
    logic                 w_start;
    logic                 w_free;
    logic                 w_load;
    t_emit                w_emit;
    logic                 w_pos_busy, w_tilt_busy;
    logic [FRAC_BITS-1:0] w_dpos, w_dtilt;
    logic [TIME_W-1:0]    w_pos_dur;
    logic [SINCE_W:0]     w_since_sum;
    logic [SINCE_W-1:0]   w_since_sat;
    logic                 w_up;
    logic [FRAC_BITS-1:0] w_new_pos, w_new_tilt;
    logic                 w_reached;
    logic                 w_end_stop;
    logic                 w_stop_send;
    logic                 w_pos_go, w_tilt_go;
    t_op                  w_pos_op, w_tilt_op;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_time  <= OPEN_TIME_RST;
            r_close_time <= CLOSE_TIME_RST;
            r_tilt_time  <= TILT_TIME_RST;
            r_addr       <= ADDR_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_OPEN_TIME:   r_open_time  <= i_cfg_data;
                REG_CLOSE_TIME:  r_close_time <= i_cfg_data;
                REG_TILT_TIME:   r_tilt_time  <= i_cfg_data;
                REG_DEVICE_ADDR: r_addr       <= i_cfg_data[ADDR_W-1:0];
            endcase
        end
    end

    // Movement dividers, position and tilt in parallel.
    assign w_pos_dur = (r_op == OP_OPENING) ? r_open_time : r_close_time;

    tcpt_serial_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_elapsed (i_elapsed_ms),
        .i_dur     (w_pos_dur),
        .o_busy    (w_pos_busy),
        .o_quot    (w_dpos)
    );

    tcpt_serial_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_tilt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_elapsed (i_elapsed_ms),
        .i_dur     (r_tilt_time),
        .o_busy    (w_tilt_busy),
        .o_quot    (w_dtilt)
    );

    // Publish counter, saturating.
    assign w_since_sum = {1'b0, r_since} + {1'b0, i_elapsed_ms};
    assign w_since_sat = w_since_sum[SINCE_W] ? {SINCE_W{1'b1}} : w_since_sum[SINCE_W-1:0];

    // Estimates after a tick and the target check.
    assign w_up        = (r_op == OP_OPENING);
    assign w_new_pos   = step_value(r_pos, w_dpos, w_up);
    assign w_new_tilt  = step_value(r_tilt, w_dtilt, w_up);
    assign w_reached   = w_up ? (w_new_pos >= r_goal_pos && w_new_tilt >= r_goal_tilt)
                              : (w_new_pos <= r_goal_pos && w_new_tilt <= r_goal_tilt);
    assign w_end_stop  = (w_up && r_goal_pos == FULL) || (!w_up && r_goal_pos == '0);
    assign w_stop_send = !w_end_stop && !r_bus_trig;

    // Control call decisions; the stop step leaves both estimates as they are,
    // so these also tell which later steps will give a result.
    assign w_pos_go  = r_has_pos && (r_tpos != r_pos || r_tpos == '0 || r_tpos == FULL);
    assign w_pos_op  = (r_tpos == r_pos) ? ((r_tpos == '0) ? OP_CLOSING : OP_OPENING)
                                         : ((r_tpos < r_pos) ? OP_CLOSING : OP_OPENING);
    assign w_tilt_go = r_has_tilt && (r_ttilt != r_tilt);
    assign w_tilt_op = (r_ttilt < r_tilt) ? OP_CLOSING : OP_OPENING;

    // Request sequencer.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_tilt      = r_tilt;
        n_goal_pos  = r_goal_pos;
        n_goal_tilt = r_goal_tilt;
        n_bus_trig  = r_bus_trig;
        n_since     = r_since;
        n_per       = r_per;
        w_start     = 1'b0;
        w_load      = 1'b0;
        w_emit      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_TICK: begin
                            n_since = w_since_sat;
                            if (r_op != OP_IDLE) begin
                                n_per   = w_since_sat > PUBLISH_PERIOD_MS;
                                w_start = 1'b1;
                                n_state = S_DIV;
                            end
                        end
                        KIND_BUS:  n_state = S_BUS;
                        KIND_CALL: n_state = S_STOP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end

            S_DIV: begin
                if (!w_pos_busy && !w_tilt_busy) begin
                    n_state = S_UPDATE;
                end
            end

            S_UPDATE: begin
                if (!w_reached) begin
                    n_pos   = w_new_pos;
                    n_tilt  = w_new_tilt;
                    n_state = r_per ? S_PERIODIC : S_IDLE;
                end else if (w_free) begin
                    n_pos               = w_new_pos;
                    n_tilt              = w_new_tilt;
                    n_op                = OP_IDLE;
                    w_load              = 1'b1;
                    w_emit.send_valid   = w_stop_send;
                    w_emit.send_command = w_stop_send ? CMD_STOP : CMD_NONE;
                    w_emit.publish      = PUB_FULL;
                    w_emit.last         = !r_per;
                    n_state             = r_per ? S_PERIODIC : S_IDLE;
                end
            end

            S_PERIODIC: begin
                if (w_free) begin
                    w_load         = 1'b1;
                    w_emit.publish = PUB_PERIODIC;
                    w_emit.last    = 1'b1;
                    n_since        = '0;
                    n_state        = S_IDLE;
                end
            end

            S_BUS: begin
                if (w_free) begin
                    case (r_bus_cmd)
                        CMD_UP: begin
                            n_goal_pos = FULL;
                            n_bus_trig = 1'b1;
                            n_op       = OP_OPENING;
                        end
                        CMD_DOWN: begin
                            n_goal_pos = '0;
                            n_bus_trig = 1'b1;
                            n_op       = OP_CLOSING;
                        end
                        CMD_STOP: begin
                            n_bus_trig = 1'b1;
                            n_op       = OP_IDLE;
                        end
                        default: begin
                            n_op = r_op;
                        end
                    endcase
                    w_load         = 1'b1;
                    w_emit.publish = PUB_FULL;
                    w_emit.last    = 1'b1;
                    n_since        = '0;
                    n_state        = S_IDLE;
                end
            end

            S_STOP: begin
                if (!r_do_stop) begin
                    n_state = S_POS;
                end else if (w_free) begin
                    n_bus_trig          = 1'b0;
                    n_op                = OP_IDLE;
                    w_load              = 1'b1;
                    w_emit.send_valid   = 1'b1;
                    w_emit.send_command = CMD_STOP;
                    w_emit.publish      = PUB_FULL;
                    w_emit.last         = !w_pos_go && !w_tilt_go;
                    n_state             = S_POS;
                end
            end

            S_POS: begin
                if (!w_pos_go) begin
                    n_state = S_TILT;
                end else if (w_free) begin
                    n_op                = w_pos_op;
                    n_goal_pos          = r_tpos;
                    n_goal_tilt         = (w_pos_op == OP_CLOSING) ? FULL : '0;
                    n_bus_trig          = 1'b0;
                    w_load              = 1'b1;
                    w_emit.send_valid   = 1'b1;
                    w_emit.send_command = op_command(w_pos_op);
                    w_emit.publish      = PUB_NONE;
                    w_emit.last         = !w_tilt_go;
                    n_state             = S_TILT;
                end
            end

            S_TILT: begin
                if (!w_tilt_go) begin
                    n_state = S_IDLE;
                end else if (w_free) begin
                    n_op                = w_tilt_op;
                    n_goal_pos          = r_pos;
                    n_goal_tilt         = r_ttilt;
                    n_bus_trig          = 1'b0;
                    w_load              = 1'b1;
                    w_emit.send_valid   = 1'b1;
                    w_emit.send_command = op_command(w_tilt_op);
                    w_emit.publish      = PUB_NONE;
                    w_emit.last         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Each result reports the operation after its own event.
        w_emit.operation = n_op;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_IDLE;
            r_pos       <= HALF;
            r_tilt      <= FULL;
            r_goal_pos  <= '0;
            r_goal_tilt <= '0;
            r_bus_trig  <= 1'b0;
            r_since     <= {SINCE_W{1'b1}};
            r_per       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_pos       <= n_pos;
            r_tilt      <= n_tilt;
            r_goal_pos  <= n_goal_pos;
            r_goal_tilt <= n_goal_tilt;
            r_bus_trig  <= n_bus_trig;
            r_since     <= n_since;
            r_per       <= n_per;
        end
    end

    // Request fields held for the steps that follow acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bus_cmd  <= i_bus_command;
            r_do_stop  <= i_do_stop;
            r_has_pos  <= i_has_position;
            r_tpos     <= i_target_pos;
            r_has_tilt <= i_has_tilt;
            r_ttilt    <= i_target_tilt_in;
        end
    end

    // Output register.
    tcpt_out_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_emit         (w_emit),
        .i_addr         (r_addr),
        .i_pos          (n_pos),
        .i_tilt         (n_tilt),
        .i_out_ready    (i_out_ready),
        .o_free         (w_free),
        .o_out_valid    (o_out_valid),
        .o_send_valid   (o_send_valid),
        .o_send_command (o_send_command),
        .o_send_address (o_send_address),
        .o_position_now (o_position_now),
        .o_tilt_now     (o_tilt_now),
        .o_operation    (o_operation),
        .o_publish      (o_publish),
        .o_last         (o_last)
    );

    // The dividers only run while the sequencer waits on them.
    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pos_busy || w_tilt_busy) |-> (r_state == S_DIV))
        else $error("divider busy outside the divide step");

    // A tick only reaches the update step while the motor runs.
    a_update_when_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> (r_op != OP_IDLE))
        else $error("estimate update while idle");

    // A periodic publish clears the counter.
    a_periodic_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PERIODIC && w_free) |=> (r_since == '0))
        else $error("publish counter not cleared after periodic publish");

endmodule

/* design/tcpt_serial_div.sv */
// ----------------------------------------------------------------------------
// tcpt_serial_div: bit-serial travel divider
// Computes min(elapsed * (2^FRAC_BITS - 1) / duration, 2^FRAC_BITS - 1),
// rounded down, one quotient bit per cycle. A zero duration counts as one.
// ----------------------------------------------------------------------------
module tcpt_serial_div #(
    parameter int FRAC_BITS = tcpt_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tcpt_pkg::ELAPSED_W-1:0] i_elapsed,
    input  logic [tcpt_pkg::TIME_W-1:0]  i_dur,
    output logic                         o_busy,
    output logic [FRAC_BITS-1:0]         o_quot
);
    import tcpt_pkg::*;

    localparam int NUM_W = ELAPSED_W + FRAC_BITS;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [TIME_W-1:0]    r_dur;
    logic [TIME_W-1:0]    r_rem;
    logic [FRAC_BITS-1:0] r_acc;

    logic [NUM_W-1:0]     w_num;
    logic [TIME_W-1:0]    w_dur;
    logic [ELAPSED_W-1:0] w_hi;
    logic                 w_sat;
    logic [TIME_W:0]      w_trial;
    logic [TIME_W:0]      w_diff;
    logic                 w_ge;
    logic [TIME_W-1:0]    n_rem;
    logic [FRAC_BITS-1:0] n_acc;

    // Dividend is elapsed * full scale; the upper part decides saturation.
    assign w_num = {i_elapsed, {FRAC_BITS{1'b0}}} - NUM_W'(i_elapsed);
    assign w_dur = (i_dur == '0) ? TIME_W'(1) : i_dur;
    assign w_hi  = w_num[NUM_W-1:FRAC_BITS];
    assign w_sat = TIME_W'(w_hi) >= w_dur;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // Quotient bits enter at the bottom of the same shift register.
    always_comb begin
        w_trial = {r_rem, r_acc[FRAC_BITS-1]};
        w_diff  = w_trial - {1'b0, r_dur};
        w_ge    = w_trial >= {1'b0, r_dur};
        n_rem   = w_ge ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
        n_acc   = {r_acc[FRAC_BITS-2:0], w_ge};
    end

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !w_sat;
            r_cnt  <= CNT_W'(FRAC_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and dividend/quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dur <= w_dur;
            r_rem <= TIME_W'(w_hi);
            r_acc <= w_sat ? {FRAC_BITS{1'b1}} : w_num[FRAC_BITS-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_acc;

    // The partial remainder always stays below the divisor.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dur))
        else $error("divider remainder not below divisor");

endmodule

/* design/tcpt_out_stage.sv */
// ----------------------------------------------------------------------------
// tcpt_out_stage: result output register
// Holds one result until the consumer takes it, so the sequencer can work on
// while a finished result waits.
// ----------------------------------------------------------------------------
module tcpt_out_stage #(
    parameter int FRAC_BITS = tcpt_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  tcpt_pkg::t_emit             i_emit,
    input  logic [tcpt_pkg::ADDR_W-1:0] i_addr,
    input  logic [FRAC_BITS-1:0]        i_pos,
    input  logic [FRAC_BITS-1:0]        i_tilt,
    input  logic                        i_out_ready,
    output logic                        o_free,
    output logic                        o_out_valid,
    output logic                        o_send_valid,
    output logic [tcpt_pkg::CMD_W-1:0]  o_send_command,
    output logic [tcpt_pkg::ADDR_W-1:0] o_send_address,
    output logic [FRAC_BITS-1:0]        o_position_now,
    output logic [FRAC_BITS-1:0]        o_tilt_now,
    output logic [1:0]                  o_operation,
    output logic [1:0]                  o_publish,
    output logic                        o_last
);
    import tcpt_pkg::*;

    logic                 r_valid;
    t_emit                r_emit;
    logic [ADDR_W-1:0]    r_addr;
    logic [FRAC_BITS-1:0] r_pos;
    logic [FRAC_BITS-1:0] r_tilt;

    // The slot can take a new result when empty or being emptied now.
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_emit <= i_emit;
            r_addr <= i_addr;
            r_pos  <= i_pos;
            r_tilt <= i_tilt;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_send_valid   = r_emit.send_valid;
    assign o_send_command = r_emit.send_command;
    assign o_send_address = r_addr;
    assign o_position_now = r_pos;
    assign o_tilt_now     = r_tilt;
    assign o_operation    = r_emit.operation;
    assign o_publish      = r_emit.publish;
    assign o_last         = r_emit.last;

    // The sequencer never overwrites a result that has not been taken.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded into an occupied output register");

endmodule
